// ===== src/lls_pkg.sv =====
// Shared types, state codes and control structs for the link loss monitor.
package lls_pkg;

  typedef enum logic [2:0] {
    ST_DECONF   = 3'd0,
    ST_DISCONN  = 3'd1,
    ST_CONN     = 3'd2,
    ST_CHAN_CHG = 3'd3,
    ST_TIMING   = 3'd4,
    ST_RECOVER  = 3'd5,
    ST_TIMED    = 3'd6
  } link_st_t;

  localparam int unsigned FreqW    = 16;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned MaxSteps = 4;
  localparam int unsigned StepCntW = $clog2(MaxSteps + 1);

  typedef struct packed {
    logic             kind;
    logic             configured;
    logic             connected;
    logic [FreqW-1:0] new_control_freq;
    logic [FreqW-1:0] new_center_freq;
  } in_t;

  typedef struct packed {
    logic [2:0]       link_status;
    logic [FreqW-1:0] cur_control_freq;
    logic [FreqW-1:0] cur_center_freq;
    logic             last;
  } out_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic load;
    logic tick;
    logic step;
    logic last;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic stable;
    logic look_stable;
  } sts_t;

endpackage

// ===== src/lls_dp.sv =====
// Datapath: link record, deadline timer, transition logic and result item.
module lls_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lls_pkg::cmd_t                  cmd,
  input  lls_pkg::in_t                   in_item,
  input  logic                           cfg_wr,
  input  logic [lls_pkg::TicksW-1:0]     cfg_data,
  output lls_pkg::sts_t                  sts,
  output lls_pkg::out_t                  step_item
);

  function automatic lls_pkg::link_st_t step_target(
    input lls_pkg::link_st_t st,
    input logic              cfgd,
    input logic              conn,
    input logic              expd,
    input logic              chan_diff
  );
    lls_pkg::link_st_t res;
    begin
      res = st;
      case (st)
        lls_pkg::ST_DECONF: begin
          if (cfgd) res = lls_pkg::ST_DISCONN;
        end
        lls_pkg::ST_DISCONN: begin
          if (!cfgd) res = lls_pkg::ST_DECONF;
          else if (conn || expd) res = lls_pkg::ST_CONN;
        end
        lls_pkg::ST_CONN: begin
          if (!cfgd) res = lls_pkg::ST_DECONF;
          else if (!conn) res = lls_pkg::ST_TIMING;
          else if (chan_diff) res = lls_pkg::ST_CHAN_CHG;
        end
        lls_pkg::ST_CHAN_CHG, lls_pkg::ST_RECOVER: begin
          res = lls_pkg::ST_CONN;
        end
        lls_pkg::ST_TIMING: begin
          if (!cfgd) res = lls_pkg::ST_DECONF;
          else if (conn) res = lls_pkg::ST_RECOVER;
          else if (expd) res = lls_pkg::ST_TIMED;
        end
        lls_pkg::ST_TIMED: begin
          if (!cfgd) res = lls_pkg::ST_DECONF;
          else if (conn) res = lls_pkg::ST_CONN;
        end
        default: begin
          res = lls_pkg::ST_DECONF;
        end
      endcase
      return res;
    end
  endfunction

  localparam int unsigned ChanW = 2 * lls_pkg::FreqW;

  lls_pkg::link_st_t         state_r, state_nxt;
  logic                      cfgd_r, cfgd_nxt;
  logic                      conn_r, conn_nxt;
  logic                      exp_r, exp_nxt;
  logic                      armed_r, armed_nxt;
  logic [ChanW-1:0]          cur_r, cur_nxt;
  logic [ChanW-1:0]          pend_r, pend_nxt;
  logic [lls_pkg::TicksW-1:0] ticks_r, ticks_nxt;
  logic [lls_pkg::TicksW-1:0] timeout_r;

  lls_pkg::link_st_t         st_step;
  lls_pkg::link_st_t         st_look;
  logic                      exp_after;
  logic [ChanW-1:0]          cur_after;
  logic [lls_pkg::TicksW-1:0] ticks_dec;

  assign ticks_dec = ticks_r - {{(lls_pkg::TicksW-1){1'b0}}, (ticks_r != '0)};

  assign st_step   = step_target(state_r, cfgd_r, conn_r, exp_r, cur_r != pend_r);
  assign exp_after = (state_r == lls_pkg::ST_TIMED || st_step == lls_pkg::ST_TIMING) ?
                     1'b0 : exp_r;
  assign cur_after = (st_step == lls_pkg::ST_CONN) ? pend_r : cur_r;
  assign st_look   = step_target(st_step, cfgd_r, conn_r, exp_after, cur_after != pend_r);

  assign sts.fire        = armed_r && (ticks_dec == '0);
  assign sts.stable      = (st_step == state_r);
  assign sts.look_stable = (st_look == st_step);

  assign step_item.link_status      = st_step;
  assign step_item.cur_control_freq = cur_after[ChanW-1:lls_pkg::FreqW];
  assign step_item.cur_center_freq  = cur_after[lls_pkg::FreqW-1:0];
  assign step_item.last             = 1'b0;

  always_comb begin
    state_nxt = state_r;
    cfgd_nxt  = cfgd_r;
    conn_nxt  = conn_r;
    exp_nxt   = exp_r;
    armed_nxt = armed_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    ticks_nxt = ticks_r;
    if (cmd.load) begin
      cfgd_nxt = in_item.configured;
      conn_nxt = in_item.connected;
      if (in_item.connected) begin
        pend_nxt = {in_item.new_control_freq, in_item.new_center_freq};
      end
    end
    if (cmd.tick && armed_r) begin
      ticks_nxt = ticks_dec;
      if (ticks_dec == '0) begin
        armed_nxt = 1'b0;
        exp_nxt   = 1'b1;
      end
    end
    if (cmd.step) begin
      state_nxt = st_step;
      exp_nxt   = exp_after;
      cur_nxt   = cur_after;
      if (state_r == lls_pkg::ST_TIMING) armed_nxt = 1'b0;
      if (st_step == lls_pkg::ST_TIMING) begin
        armed_nxt = 1'b1;
        ticks_nxt = timeout_r;
      end
    end
    if (cmd.finish && state_r == lls_pkg::ST_DECONF) begin
      state_nxt = lls_pkg::ST_DECONF;
      cfgd_nxt  = 1'b0;
      conn_nxt  = 1'b0;
      exp_nxt   = 1'b0;
      armed_nxt = 1'b0;
      cur_nxt   = '0;
      pend_nxt  = '0;
      ticks_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lls_pkg::ST_DECONF;
      cfgd_r    <= 1'b0;
      conn_r    <= 1'b0;
      exp_r     <= 1'b0;
      armed_r   <= 1'b0;
      cur_r     <= '0;
      pend_r    <= '0;
      ticks_r   <= '0;
      timeout_r <= '0;
    end else begin
      state_r <= state_nxt;
      cfgd_r  <= cfgd_nxt;
      conn_r  <= conn_nxt;
      exp_r   <= exp_nxt;
      armed_r <= armed_nxt;
      cur_r   <= cur_nxt;
      pend_r  <= pend_nxt;
      ticks_r <= ticks_nxt;
      if (cfg_wr) timeout_r <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  a_armed_timing: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> state_r == lls_pkg::ST_TIMING)
    else $error("deadline armed while not timing out");
  a_expired_state: assert property (@(posedge clk) disable iff (!rst_n)
    exp_r |-> (state_r == lls_pkg::ST_TIMING || state_r == lls_pkg::ST_TIMED))
    else $error("expired flag held in wrong state");
  a_clear_record: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && state_r == lls_pkg::ST_DECONF) |=>
      (!armed_r && !cfgd_r && cur_r == '0 && pend_r == '0))
    else $error("link record not cleared after settling in deconfigured");
`endif

endmodule

// ===== src/lls_ctrl.sv =====
// Controller: accepts items and sequences the transition run.
module lls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_stall,
  input  logic          out_free,
  input  lls_pkg::sts_t sts,
  output lls_pkg::cmd_t cmd
);

  typedef enum logic {
    C_IDLE,
    C_RUN
  } ctrl_st_t;

  ctrl_st_t                       state_r, state_nxt;
  logic [lls_pkg::StepCntW-1:0]   cnt_r, cnt_nxt;
  logic                           cnt_full;

  localparam logic [lls_pkg::StepCntW-1:0] CntMax  = lls_pkg::StepCntW'(lls_pkg::MaxSteps);
  localparam logic [lls_pkg::StepCntW-1:0] CntLast = lls_pkg::StepCntW'(lls_pkg::MaxSteps - 1);

  assign cnt_full = (cnt_r == CntMax);
  assign in_stall = (state_r != C_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      C_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          if (in_kind == lls_pkg::KIND_STATUS) begin
            cmd.load  = 1'b1;
            state_nxt = C_RUN;
          end else begin
            cmd.tick = 1'b1;
            if (sts.fire) state_nxt = C_RUN;
          end
        end
      end
      C_RUN: begin
        if (!sts.stable && !cnt_full) begin
          if (out_free) begin
            cmd.step = 1'b1;
            cmd.last = sts.look_stable || (cnt_r == CntLast);
            cnt_nxt  = cnt_r + 1'b1;
          end
        end else begin
          cmd.finish = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = C_IDLE;
        end
      end
      default: begin
        state_nxt = C_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_IDLE |-> cnt_r == '0)
    else $error("step count not cleared in idle");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && cmd.last && sts.look_stable) |=> (state_r == C_RUN && sts.stable))
    else $error("run continued after final transition");
`endif

endmodule

// ===== src/link_loss_monitor.sv =====
// Top level of the link loss monitor: controller, datapath and result register.
//
//   channel | direction | handshake         | payload
//   in      | input     | in_valid/in_stall | lls_pkg::in_t
//   out     | output    | out_valid/out_stall | lls_pkg::out_t
//   cfg     | input     | cfg_valid/cfg_ready | timeout_ticks, 32 bits
//
// A status update starts a run of n transitions (0 to 4); the settle loop
// produces one transition per cycle through the next-state logic while the output is free.
// A tick that fires starts the same kind of run; a tick that does not fire starts none.
// Input is stalled while a run is in progress; out_stall holds the loop.
// Synchronous reset clears the link record, the timeout register and the result register.
module link_loss_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lls_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lls_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lls_pkg::TicksW-1:0]     cfg_data
);

  lls_pkg::cmd_t cmd;
  lls_pkg::sts_t sts;
  lls_pkg::out_t step_item;
  lls_pkg::out_t step_out;
  logic          out_valid_r;
  lls_pkg::out_t out_data_r;
  logic          out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  lls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  lls_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .step_item (step_item)
  );

  always_comb begin
    step_out      = step_item;
    step_out.last = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_data_r <= '0;
    end else if (cmd.step) begin
      out_data_r <= step_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/link_loss_monitor_checker.sv =====
// Link loss monitor checker: tracks the link record from observed transfers and compares results.
module link_loss_monitor_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  lls_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  lls_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lls_pkg::TicksW-1:0]    cfg_data,
  output int                            err_count = 0,
  output int                            transitions_left = 0
);

  lls_pkg::link_st_t          lnk_st;
  bit                         lnk_cfgd;
  bit                         lnk_conn;
  bit                         lnk_expired;
  bit [31:0]                  cur_chan;
  bit [31:0]                  pend_chan;
  bit                         dl_armed;
  bit [lls_pkg::TicksW-1:0]   dl_left;
  bit [lls_pkg::TicksW-1:0]   timeout_reg;

  lls_pkg::out_t              transitions_q[$];

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic clear_link();
    lnk_st      = lls_pkg::ST_DECONF;
    lnk_cfgd    = 1'b0;
    lnk_conn    = 1'b0;
    lnk_expired = 1'b0;
    cur_chan    = '0;
    pend_chan   = '0;
    dl_armed    = 1'b0;
    dl_left     = '0;
  endtask

  function automatic lls_pkg::link_st_t next_link_state();
    lls_pkg::link_st_t nxt;
    nxt = lnk_st;
    case (lnk_st)
      lls_pkg::ST_DECONF: begin
        if (lnk_cfgd) nxt = lls_pkg::ST_DISCONN;
      end
      lls_pkg::ST_DISCONN: begin
        if (!lnk_cfgd) nxt = lls_pkg::ST_DECONF;
        else if (lnk_conn) nxt = lls_pkg::ST_CONN;
        else if (lnk_expired) nxt = lls_pkg::ST_CONN;
      end
      lls_pkg::ST_CONN: begin
        if (!lnk_cfgd) nxt = lls_pkg::ST_DECONF;
        else if (!lnk_conn) nxt = lls_pkg::ST_TIMING;
        else if (cur_chan != pend_chan) nxt = lls_pkg::ST_CHAN_CHG;
      end
      lls_pkg::ST_CHAN_CHG, lls_pkg::ST_RECOVER: begin
        nxt = lls_pkg::ST_CONN;
      end
      lls_pkg::ST_TIMING: begin
        if (!lnk_cfgd) nxt = lls_pkg::ST_DECONF;
        else if (lnk_conn) nxt = lls_pkg::ST_RECOVER;
        else if (lnk_expired) nxt = lls_pkg::ST_TIMED;
      end
      lls_pkg::ST_TIMED: begin
        if (!lnk_cfgd) nxt = lls_pkg::ST_DECONF;
        else if (lnk_conn) nxt = lls_pkg::ST_CONN;
      end
      default: begin
        nxt = lls_pkg::ST_DECONF;
      end
    endcase
    return nxt;
  endfunction

  task automatic settle_link();
    lls_pkg::out_t     steps[lls_pkg::MaxSteps];
    lls_pkg::link_st_t prev;
    lls_pkg::link_st_t nxt;
    int                n;
    bit                stable;
    n = 0;
    stable = 1'b0;
    while (n < lls_pkg::MaxSteps && !stable) begin
      prev = lnk_st;
      nxt  = next_link_state();
      if (nxt == prev) begin
        stable = 1'b1;
      end else begin
        lnk_st = nxt;
        if (prev == lls_pkg::ST_TIMING) dl_armed = 1'b0;
        if (prev == lls_pkg::ST_TIMED) lnk_expired = 1'b0;
        if (nxt == lls_pkg::ST_CONN) cur_chan = pend_chan;
        if (nxt == lls_pkg::ST_TIMING) begin
          lnk_expired = 1'b0;
          dl_armed    = 1'b1;
          dl_left     = timeout_reg;
        end
        steps[n].link_status      = lnk_st;
        steps[n].cur_control_freq = cur_chan[31:16];
        steps[n].cur_center_freq  = cur_chan[15:0];
        steps[n].last             = 1'b0;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) steps[i].last = 1'b1;
      transitions_q.push_back(steps[i]);
    end
    if (lnk_st == lls_pkg::ST_DECONF) clear_link();
  endtask

  task automatic apply_item(lls_pkg::in_t it);
    if (it.kind == lls_pkg::KIND_STATUS) begin
      lnk_cfgd = it.configured;
      lnk_conn = it.connected;
      if (it.connected) pend_chan = {it.new_control_freq, it.new_center_freq};
      settle_link();
    end else if (dl_armed) begin
      if (dl_left > 0) dl_left--;
      if (dl_left == 0) begin
        dl_armed    = 1'b0;
        lnk_expired = 1'b1;
        settle_link();
      end
    end
  endtask

  always @(posedge clk) begin
    lls_pkg::out_t want;
    if (!rst_n) begin
      timeout_reg = '0;
      clear_link();
      transitions_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (transitions_q.size() == 0) begin
          flag_mismatch("unexpected result", 32'(out_data.link_status), '0);
        end else begin
          want = transitions_q.pop_front();
          if (out_data.link_status != want.link_status)
            flag_mismatch("link_status", 32'(out_data.link_status),
                          32'(want.link_status));
          if (out_data.cur_control_freq != want.cur_control_freq)
            flag_mismatch("cur_control_freq", 32'(out_data.cur_control_freq),
                          32'(want.cur_control_freq));
          if (out_data.cur_center_freq != want.cur_center_freq)
            flag_mismatch("cur_center_freq", 32'(out_data.cur_center_freq),
                          32'(want.cur_center_freq));
          if (out_data.last != want.last)
            flag_mismatch("last", 32'(out_data.last), 32'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) timeout_reg = cfg_data;
      if (in_valid && !in_stall) apply_item(in_data);
    end
    transitions_left <= transitions_q.size();
  end

endmodule

// ===== tb/link_loss_monitor_tb.sv =====
// Link loss monitor testbench top: clock, reset, stimulus, watchdog and verdict.
module link_loss_monitor_tb;

  localparam int StallLimit  = 2000;
  localparam int SettleWait  = 10;
  localparam int RandPerPhase = 60;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  lls_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  lls_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lls_pkg::TicksW-1:0]    cfg_data = '0;

  int                   err_count;
  int                   transitions_left;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;
  bit                   finished = 1'b0;

  link_loss_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  link_loss_monitor_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .err_count        (err_count),
    .transitions_left (transitions_left)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!finished) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic lls_pkg::in_t status_item(bit cfgd, bit conn,
                                               logic [lls_pkg::FreqW-1:0] ctl,
                                               logic [lls_pkg::FreqW-1:0] ctr);
    lls_pkg::in_t it;
    it.kind             = lls_pkg::KIND_STATUS;
    it.configured       = cfgd;
    it.connected        = conn;
    it.new_control_freq = ctl;
    it.new_center_freq  = ctr;
    return it;
  endfunction

  function automatic lls_pkg::in_t tick_item();
    lls_pkg::in_t it;
    it      = lls_pkg::in_t'($urandom());
    it.kind = lls_pkg::KIND_TICK;
    return it;
  endfunction

  function automatic lls_pkg::in_t random_item();
    lls_pkg::in_t              it;
    logic [lls_pkg::FreqW-1:0] ctl;
    logic [lls_pkg::FreqW-1:0] ctr;
    if ($urandom_range(99) < 40) return tick_item();
    case ($urandom_range(4))
      0: begin ctl = 16'd2412; ctr = 16'd2412; end
      1: begin ctl = 16'd5180; ctr = 16'd5190; end
      2: begin ctl = 16'd5745; ctr = 16'd5775; end
      default: begin ctl = 16'($urandom()); ctr = 16'($urandom()); end
    endcase
    it = status_item($urandom_range(99) < 92, $urandom_range(99) < 55, ctl, ctr);
    return it;
  endfunction

  task automatic send_item(lls_pkg::in_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (transitions_left != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_timeout(logic [lls_pkg::TicksW-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int pcts[4][2];
    pcts = '{'{0, 0}, '{52, 0}, '{0, 52}, '{34, 34}};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // timeout at its reset value: fires on the next tick
    send_item(tick_item());
    send_item(status_item(1'b0, 1'b1, 16'h1234, 16'h5678));
    send_item(status_item(1'b1, 1'b0, 16'h0000, 16'h0000));
    send_item(status_item(1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    send_item(status_item(1'b1, 1'b1, 16'h0000, 16'h0000));
    send_item(status_item(1'b1, 1'b1, 16'h0000, 16'h0000));
    send_item(status_item(1'b1, 1'b0, 16'($urandom()), 16'($urandom())));
    send_item(tick_item());
    send_item(status_item(1'b1, 1'b0, 16'($urandom()), 16'($urandom())));
    send_item(status_item(1'b1, 1'b1, 16'h1111, 16'h2222));
    send_item(status_item(1'b1, 1'b0, 16'h1111, 16'h2222));
    send_item(status_item(1'b1, 1'b1, 16'h1111, 16'h2222));
    send_item(status_item(1'b1, 1'b0, 16'h1111, 16'h2222));
    send_item(status_item(1'b1, 1'b1, 16'h3333, 16'h4444));
    send_item(status_item(1'b0, 1'b1, 16'h3333, 16'h4444));
    send_item(status_item(1'b1, 1'b1, 16'hAAAA, 16'h5555));
    send_item(status_item(1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
    drain();

    write_timeout(32'd3);
    send_item(status_item(1'b1, 1'b1, 16'hF0F0, 16'h0F0F));
    send_item(status_item(1'b1, 1'b0, 16'h0000, 16'h0000));
    repeat (3) send_item(tick_item());
    send_item(status_item(1'b0, 1'b0, 16'h0000, 16'h0000));
    drain();

    write_timeout(32'hFFFF_FFFF);
    send_item(status_item(1'b1, 1'b1, 16'h0F0F, 16'hF0F0));
    send_item(status_item(1'b1, 1'b0, 16'h0000, 16'h0000));
    repeat (2) send_item(tick_item());
    send_item(status_item(1'b1, 1'b1, 16'h0F0F, 16'hF0F0));
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_timeout(32'd0);
        1: write_timeout($urandom_range(5, 2));
        2: write_timeout(32'd1);
        default: write_timeout($urandom_range(8, 3));
      endcase
      idle_pct  = pcts[p][0];
      stall_pct = pcts[p][1];
      repeat (RandPerPhase) send_item(random_item());
      drain();
    end

    finished = 1'b1;
    if (err_count == 0 && transitions_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
